// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds on every rising clock edge outside reset.
`define RRTS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds outside reset.
`define RRTS_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RRTS_ASSERT(lbl, clk, rst, prop, msg)
`define RRTS_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/rrts_pkg.sv =====
// Shared constants and helpers of the round-robin time-slice scheduler.
// No dependencies; used by the task store and the top level.
package rrts_pkg;

  // Port field widths
  localparam int OPCODE_W   = 2;
  localparam int TASK_ID_W  = 5;
  localparam int PRIO_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 6;
  localparam int SLICE_O_W  = 8;
  localparam int ELAPSED_W  = 32;

  // Parameter defaults
  localparam int MAX_TASKS_DEF  = 32;
  localparam int SLICE_BITS_DEF = 8;
  localparam int MAIN_TASK_DEF  = 0;

  // Reset value of the main task priority register
  localparam logic [PRIO_W-1:0] MAIN_PRIO_RESET = 8'd31;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CREATE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_STATUS = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_EXIT   = 2'd3;

  // Task status codes
  localparam logic [STATUS_W-1:0] ST_READY   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RUNNING = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HANGING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIED    = 3'd4;

  // Saturate an 8-bit priority to a slice field of sb bits
  function automatic logic [31:0] sat_slice(input logic [PRIO_W-1:0] v, input int sb);
    logic [31:0] lim;
    lim = (32'd1 << sb) - 32'd1;
    if (sb >= PRIO_W) begin
      return {24'd0, v};
    end
    return ({24'd0, v} > lim) ? lim : {24'd0, v};
  endfunction

endpackage

// ===== hw/rtl/rrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rrts_task_store.sv =====
// Task record store: RAM plus per-entry valid bits; unwritten entries read as reset records.
// Depends on rrts_pkg and rrts_ram.
module rrts_task_store #(
  parameter int MAX_TASKS  = rrts_pkg::MAX_TASKS_DEF,
  parameter int SLICE_BITS = rrts_pkg::SLICE_BITS_DEF,
  parameter int MAIN_TASK  = rrts_pkg::MAIN_TASK_DEF,
  parameter int TW         = $clog2(MAX_TASKS),
  parameter int W          = rrts_pkg::STATUS_W + 2 * SLICE_BITS + rrts_pkg::ELAPSED_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [TW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [TW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [MAX_TASKS-1:0]  vld;
  logic                  vld_q;
  logic                  main_q;
  logic [W-1:0]          ram_rdata;
  logic [SLICE_BITS-1:0] main_slice;
  logic [W-1:0]          main_rec;
  logic [W-1:0]          dead_rec;

  rrts_ram #(.W(W), .DEPTH(MAX_TASKS), .AW(TW)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // Mark written entries; register the lookup alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
    vld_q  <= vld[raddr];
    main_q <= (raddr == TW'(MAIN_TASK));
  end

  // Reset records: main task running with the reset priority, others dead
  assign main_slice = SLICE_BITS'(rrts_pkg::sat_slice(rrts_pkg::MAIN_PRIO_RESET, SLICE_BITS));
  assign main_rec   = {rrts_pkg::ST_RUNNING, main_slice, main_slice,
                       {rrts_pkg::ELAPSED_W{1'b0}}};
  assign dead_rec   = {rrts_pkg::ST_DIED, {(W - rrts_pkg::STATUS_W){1'b0}}};

  assign rdata = vld_q ? ram_rdata : (main_q ? main_rec : dead_rec);

endmodule

// ===== hw/rtl/round_robin_time_slice_scheduler.sv =====
// Round-robin time-slice task scheduler. One command item (tick, create, set status, exit)
// gives one result item. How long an item takes depends on its path, from a tick that only
// spends slice time to an exit that unlinks, switches and requeues; it is set by the
// read-modify-write steps on the link memory (one read and one write port, registered read
// data). A configuration write reads and then rewrites the main task record. No clearing pass is needed after reset.
`include "assert_macros.svh"

module round_robin_time_slice_scheduler #(
  parameter int MAX_TASKS  = rrts_pkg::MAX_TASKS_DEF,
  parameter int SLICE_BITS = rrts_pkg::SLICE_BITS_DEF,
  parameter int MAIN_TASK  = rrts_pkg::MAIN_TASK_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rrts_pkg::PRIO_W-1:0]    main_task_priority,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rrts_pkg::OPCODE_W-1:0]  opcode,
  input  logic [rrts_pkg::TASK_ID_W-1:0] task_id,
  input  logic [rrts_pkg::PRIO_W-1:0]    priority_req,
  input  logic [rrts_pkg::STATUS_W-1:0]  new_status,
  input  logic                           to_front,
  input  logic                           sched_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rrts_pkg::TASK_ID_W-1:0] current_task,
  output logic [rrts_pkg::TASK_ID_W-1:0] previous_task,
  output logic                           switched,
  output logic [rrts_pkg::COUNT_W-1:0]   ready_count,
  output logic [rrts_pkg::SLICE_O_W-1:0] slice_left
);

  localparam int TW     = $clog2(MAX_TASKS);
  localparam int NW     = $clog2(MAX_TASKS + 1);
  localparam int TREC_W = rrts_pkg::STATUS_W + 2 * SLICE_BITS + rrts_pkg::ELAPSED_W;
  localparam logic [NW-1:0] NIL = NW'(MAX_TASKS);

  typedef struct packed {
    logic [rrts_pkg::STATUS_W-1:0]  status;
    logic [SLICE_BITS-1:0]          prio;
    logic [SLICE_BITS-1:0]          slice;
    logic [rrts_pkg::ELAPSED_W-1:0] elapsed;
  } trec_t;

  typedef struct packed {
    logic [NW-1:0] nxt;
    logic [NW-1:0] prv;
  } link_t;

  typedef enum logic [18:0] {
    S_IDLE   = 19'h00001,
    S_CFG_RD = 19'h00002,
    S_CFG_WR = 19'h00004,
    S_CREATE = 19'h00008,
    S_ST_RD  = 19'h00010,
    S_ST_WR  = 19'h00020,
    S_UL0    = 19'h00040,
    S_UL1    = 19'h00080,
    S_UL2    = 19'h00100,
    S_UL3    = 19'h00200,
    S_AP0    = 19'h00400,
    S_AP1    = 19'h00800,
    S_SC0    = 19'h01000,
    S_SC1    = 19'h02000,
    S_SC2    = 19'h04000,
    S_SC3    = 19'h08000,
    S_SC4    = 19'h10000,
    S_FIN0   = 19'h20000,
    S_FIN1   = 19'h40000
  } state_t;

  state_t state;
  state_t ret;

  // Queue and running-task registers
  logic [NW-1:0]        head;
  logic [NW-1:0]        tail;
  logic [NW-1:0]        count;
  logic [TW-1:0]        running;
  logic [MAX_TASKS-1:0] queued;

  // Latched item and work registers
  logic [TW-1:0]                 t_q;
  logic [rrts_pkg::PRIO_W-1:0]   prio_q;
  logic [rrts_pkg::STATUS_W-1:0] st_q;
  logic                          front_q;
  logic                          sched_q;
  logic [rrts_pkg::PRIO_W-1:0]   cfg_q;
  logic [TW-1:0]                 prev_run;
  logic [TW-1:0]                 sc_cur;
  logic [TW-1:0]                 nx;
  trec_t                         cr;
  logic [TW-1:0]                 lk_x;
  logic                          lk_push;
  logic                          lk_front;
  logic [NW-1:0]                 ulp;
  logic [NW-1:0]                 uln;

  // Memory ports
  logic              t_we;
  logic [TW-1:0]     t_waddr;
  trec_t             t_wrec;
  logic [TW-1:0]     t_raddr;
  logic [TREC_W-1:0] t_rdata;
  trec_t             trd;
  logic              l_we;
  logic [TW-1:0]     l_waddr;
  link_t             l_wrec;
  logic [TW-1:0]     l_raddr;
  logic [2*NW-1:0]   l_rdata;
  link_t             lrd;

  logic [NW-1:0]         anchor;
  logic [NW-1:0]         x_link;
  logic                  tick_run;
  logic                  in_range;
  logic                  out_load;
  logic                  q_empty;
  logic [SLICE_BITS-1:0] cfg_slice;
  logic [SLICE_BITS-1:0] req_slice;

  rrts_task_store #(
    .MAX_TASKS(MAX_TASKS), .SLICE_BITS(SLICE_BITS), .MAIN_TASK(MAIN_TASK),
    .TW(TW), .W(TREC_W)
  ) u_tasks (
    .clk  (clk),
    .rst  (rst),
    .we   (t_we),
    .waddr(t_waddr),
    .wdata(t_wrec),
    .raddr(t_raddr),
    .rdata(t_rdata)
  );

  rrts_ram #(.W(2 * NW), .DEPTH(MAX_TASKS), .AW(TW)) u_links (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wrec),
    .raddr(l_raddr),
    .rdata(l_rdata)
  );

  assign trd       = trec_t'(t_rdata);
  assign lrd       = link_t'(l_rdata);
  assign anchor    = lk_front ? head : tail;
  assign x_link    = NW'(lk_x);
  assign tick_run  = (trd.status == rrts_pkg::ST_RUNNING) && (trd.slice != '0);
  assign in_range  = (int'(task_id) < MAX_TASKS);
  assign out_load  = (state == S_FIN1) && (!out_valid || out_ready);
  assign q_empty   = (count == '0);
  assign cfg_slice = SLICE_BITS'(rrts_pkg::sat_slice(cfg_q, SLICE_BITS));
  assign req_slice = SLICE_BITS'(rrts_pkg::sat_slice(prio_q, SLICE_BITS));
  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // Task memory read address and write request
  always_comb begin
    t_raddr = running;
    t_we    = 1'b0;
    t_waddr = running;
    t_wrec  = trd;
    case (state)
      S_CFG_RD: begin
        t_raddr = TW'(MAIN_TASK);
      end
      S_CFG_WR: begin
        t_raddr     = TW'(MAIN_TASK);
        t_we        = 1'b1;
        t_waddr     = TW'(MAIN_TASK);
        t_wrec.prio = cfg_slice;
      end
      S_CREATE: begin
        t_we    = 1'b1;
        t_waddr = t_q;
        t_wrec  = '{status: rrts_pkg::ST_READY, prio: req_slice, slice: req_slice,
                    elapsed: '0};
      end
      S_ST_RD: begin
        t_raddr = t_q;
      end
      S_ST_WR: begin
        t_raddr       = t_q;
        t_we          = 1'b1;
        t_waddr       = t_q;
        t_wrec.status = st_q;
      end
      S_SC1: begin
        t_we           = tick_run;
        t_wrec.slice   = trd.slice - 1'b1;
        t_wrec.elapsed = trd.elapsed + 1'b1;
      end
      S_SC2: begin
        t_raddr = nx;
      end
      S_SC3: begin
        t_raddr       = nx;
        t_we          = 1'b1;
        t_waddr       = nx;
        t_wrec.status = rrts_pkg::ST_RUNNING;
        t_wrec.slice  = trd.prio;
      end
      S_SC4: begin
        t_we          = 1'b1;
        t_waddr       = sc_cur;
        t_wrec        = cr;
        t_wrec.status = rrts_pkg::ST_READY;
      end
      default: begin
        t_raddr = running;
      end
    endcase
  end

  // Link memory read address and write request
  always_comb begin
    l_raddr = lk_x;
    l_we    = 1'b0;
    l_waddr = lk_x;
    l_wrec  = '{nxt: NIL, prv: NIL};
    case (state)
      S_UL1: begin
        l_raddr = lrd.prv[TW-1:0];
      end
      S_UL2: begin
        l_raddr = uln[TW-1:0];
        l_we    = (ulp != NIL);
        l_waddr = ulp[TW-1:0];
        l_wrec  = '{nxt: uln, prv: lrd.prv};
      end
      S_UL3: begin
        l_we    = (uln != NIL);
        l_waddr = uln[TW-1:0];
        l_wrec  = '{nxt: lrd.nxt, prv: ulp};
      end
      S_AP0: begin
        l_raddr = anchor[TW-1:0];
        l_we    = 1'b1;
        l_waddr = lk_x;
        l_wrec  = lk_front ? link_t'{nxt: head, prv: NIL} : link_t'{nxt: NIL, prv: tail};
      end
      S_AP1: begin
        l_we    = (anchor != NIL);
        l_waddr = anchor[TW-1:0];
        l_wrec  = lk_front ? link_t'{nxt: lrd.nxt, prv: x_link}
                           : link_t'{nxt: x_link, prv: lrd.prv};
      end
      default: begin
        l_raddr = lk_x;
      end
    endcase
  end

  // Sequencer: configuration write, decode, unlink, append, schedule, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= NIL;
      tail    <= NIL;
      count   <= '0;
      running <= TW'(MAIN_TASK);
      queued  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            cfg_q <= main_task_priority;
            state <= S_CFG_RD;
          end else if (in_valid) begin
            t_q      <= TW'(task_id);
            prio_q   <= priority_req;
            st_q     <= (opcode == rrts_pkg::OP_EXIT) ? rrts_pkg::ST_DIED : new_status;
            front_q  <= (opcode == rrts_pkg::OP_EXIT) ? 1'b0 : to_front;
            sched_q  <= sched_req;
            prev_run <= running;
            case (opcode)
              rrts_pkg::OP_TICK: begin
                state <= S_SC0;
              end
              rrts_pkg::OP_CREATE: begin
                state <= in_range ? S_CREATE : S_FIN0;
              end
              rrts_pkg::OP_STATUS: begin
                state <= (in_range && new_status <= rrts_pkg::ST_DIED) ? S_ST_RD : S_FIN0;
              end
              default: begin
                state <= in_range ? S_ST_RD : S_FIN0;
              end
            endcase
          end
        end
        S_CFG_RD: begin
          state <= S_CFG_WR;
        end
        S_CFG_WR: begin
          state <= S_IDLE;
        end
        S_CREATE: begin
          lk_x     <= t_q;
          lk_push  <= 1'b1;
          lk_front <= 1'b0;
          ret      <= S_FIN0;
          state    <= S_UL0;
        end
        S_ST_RD: begin
          state <= S_ST_WR;
        end
        S_ST_WR: begin
          lk_x     <= t_q;
          lk_front <= front_q;
          ret      <= sched_q ? S_SC0 : S_FIN0;
          if (trd.status != rrts_pkg::ST_READY && trd.status != rrts_pkg::ST_RUNNING &&
              st_q == rrts_pkg::ST_READY) begin
            lk_push <= 1'b1;
            state   <= S_UL0;
          end else if (st_q != rrts_pkg::ST_READY) begin
            lk_push <= 1'b0;
            state   <= S_UL0;
          end else begin
            state <= sched_q ? S_SC0 : S_FIN0;
          end
        end
        // Unlink lk_x if queued
        S_UL0: begin
          if (queued[lk_x]) begin
            state <= S_UL1;
          end else begin
            state <= lk_push ? S_AP0 : ret;
          end
        end
        S_UL1: begin
          ulp <= lrd.prv;
          uln <= lrd.nxt;
          if (lrd.prv == NIL) begin
            head <= lrd.nxt;
          end
          state <= S_UL2;
        end
        S_UL2: begin
          if (uln == NIL) begin
            tail <= ulp;
          end
          state <= S_UL3;
        end
        S_UL3: begin
          queued[lk_x] <= 1'b0;
          count        <= count - 1'b1;
          state        <= lk_push ? S_AP0 : ret;
        end
        // Append lk_x at head or tail
        S_AP0: begin
          state <= S_AP1;
        end
        S_AP1: begin
          if (lk_front) begin
            head <= x_link;
            if (anchor == NIL) begin
              tail <= x_link;
            end
          end else begin
            tail <= x_link;
            if (anchor == NIL) begin
              head <= x_link;
            end
          end
          queued[lk_x] <= 1'b1;
          count        <= count + 1'b1;
          state        <= ret;
        end
        // Schedule step
        S_SC0: begin
          sc_cur <= running;
          state  <= S_SC1;
        end
        S_SC1: begin
          cr <= trd;
          if (tick_run || head == NIL) begin
            state <= S_FIN0;
          end else begin
            nx      <= head[TW-1:0];
            lk_x    <= head[TW-1:0];
            lk_push <= 1'b0;
            ret     <= S_SC2;
            state   <= S_UL0;
          end
        end
        S_SC2: begin
          state <= S_SC3;
        end
        S_SC3: begin
          if (nx == sc_cur) begin
            state <= S_FIN0;
          end else begin
            running <= nx;
            if (cr.status == rrts_pkg::ST_RUNNING || cr.status == rrts_pkg::ST_READY) begin
              state <= S_SC4;
            end else begin
              state <= S_FIN0;
            end
          end
        end
        S_SC4: begin
          lk_x     <= sc_cur;
          lk_push  <= 1'b1;
          lk_front <= 1'b0;
          ret      <= S_FIN0;
          state    <= S_UL0;
        end
        S_FIN0: begin
          state <= S_FIN1;
        end
        S_FIN1: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: hold the result item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      current_task  <= rrts_pkg::TASK_ID_W'(running);
      previous_task <= rrts_pkg::TASK_ID_W'(prev_run);
      switched      <= (running != prev_run);
      ready_count   <= rrts_pkg::COUNT_W'(count);
      slice_left    <= rrts_pkg::SLICE_O_W'(trd.slice);
    end
  end

  `RRTS_ASSERT(a_state_onehot, clk, rst, $onehot(state), "state register not one-hot")
  `RRTS_NEVER(a_count_range, clk, rst, count > NW'(MAX_TASKS), "queue count above task count")
  `RRTS_ASSERT(a_head_count, clk, rst, (state == S_IDLE) |-> ((head == NIL) == q_empty), "head")
  `RRTS_ASSERT(a_tail_count, clk, rst, (state == S_IDLE) |-> ((tail == NIL) == q_empty), "tail")
  `RRTS_ASSERT(a_one_item, clk, rst, (in_valid && in_ready) |=> !in_ready, "item taken while busy")

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for the round-robin time-slice scheduler.
// Needs rrts_pkg and round_robin_time_slice_scheduler; predicts each result item itself.
module testbench;

  localparam int NTASK = 32;
  localparam logic [5:0] NIL = 6'd32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rrts_pkg::PRIO_W-1:0] main_task_priority = rrts_pkg::MAIN_PRIO_RESET;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [rrts_pkg::OPCODE_W-1:0] opcode = rrts_pkg::OP_TICK;
  logic [rrts_pkg::TASK_ID_W-1:0] task_id = '0;
  logic [rrts_pkg::PRIO_W-1:0] priority_req = 8'd1;
  logic [rrts_pkg::STATUS_W-1:0] new_status = rrts_pkg::ST_READY;
  logic to_front = 1'b0;
  logic sched_req = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rrts_pkg::TASK_ID_W-1:0] current_task, previous_task;
  logic switched;
  logic [rrts_pkg::COUNT_W-1:0] ready_count;
  logic [rrts_pkg::SLICE_O_W-1:0] slice_left;

  round_robin_time_slice_scheduler uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .main_task_priority(main_task_priority),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .task_id(task_id),
    .priority_req(priority_req), .new_status(new_status), .to_front(to_front),
    .sched_req(sched_req), .out_valid(out_valid), .out_ready(out_ready),
    .current_task(current_task), .previous_task(previous_task), .switched(switched),
    .ready_count(ready_count), .slice_left(slice_left)
  );

  typedef struct packed {
    logic [4:0] cur;
    logic [4:0] prev;
    logic       sw;
    logic [5:0] cnt;
    logic [7:0] slice;
  } sched_result_t;

  // Shadow scheduler state
  logic [2:0]  sh_status [NTASK];
  logic [7:0]  sh_prio [NTASK];
  logic [7:0]  sh_slice [NTASK];
  logic [31:0] sh_elapsed [NTASK];
  logic [5:0]  sh_next [NTASK];
  logic [5:0]  sh_prev [NTASK];
  logic        sh_queued [NTASK];
  logic [5:0]  sh_head, sh_tail, sh_count;
  logic [4:0]  sh_running;

  sched_result_t pending_results[$];
  int errors = 0;
  int hold_off = 0;
  int rx_wait = 0;
  bit rand_stall = 1'b1;

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch %s: got %0d want %0d", what, got, want);
  endtask

  function automatic void shadow_reset();
    for (int i = 0; i < NTASK; i++) begin
      sh_status[i] = rrts_pkg::ST_DIED;
      sh_prio[i] = '0;
      sh_slice[i] = '0;
      sh_elapsed[i] = '0;
      sh_next[i] = NIL;
      sh_prev[i] = NIL;
      sh_queued[i] = 1'b0;
    end
    sh_status[0] = rrts_pkg::ST_RUNNING;
    sh_prio[0] = rrts_pkg::MAIN_PRIO_RESET;
    sh_slice[0] = rrts_pkg::MAIN_PRIO_RESET;
    sh_head = NIL;
    sh_tail = NIL;
    sh_count = '0;
    sh_running = '0;
  endfunction

  function automatic void unlink(input int t);
    logic [5:0] p, n;
    if (!sh_queued[t]) return;
    p = sh_prev[t];
    n = sh_next[t];
    if (p != NIL) sh_next[p] = n; else sh_head = n;
    if (n != NIL) sh_prev[n] = p; else sh_tail = p;
    sh_prev[t] = NIL;
    sh_next[t] = NIL;
    sh_queued[t] = 1'b0;
    sh_count--;
  endfunction

  function automatic void enqueue(input int t, input bit front);
    unlink(t);
    if (front) begin
      sh_next[t] = sh_head;
      sh_prev[t] = NIL;
      if (sh_head != NIL) sh_prev[sh_head] = 6'(t); else sh_tail = 6'(t);
      sh_head = 6'(t);
    end else begin
      sh_prev[t] = sh_tail;
      sh_next[t] = NIL;
      if (sh_tail != NIL) sh_next[sh_tail] = 6'(t); else sh_head = 6'(t);
      sh_tail = 6'(t);
    end
    sh_queued[t] = 1'b1;
    sh_count++;
  endfunction

  function automatic void run_schedule();
    int cur, nx;
    cur = int'(sh_running);
    if (sh_status[cur] == rrts_pkg::ST_RUNNING && sh_slice[cur] > 0) begin
      sh_elapsed[cur]++;
      sh_slice[cur]--;
      return;
    end
    if (sh_head == NIL) return;
    nx = int'(sh_head);
    unlink(nx);
    sh_slice[nx] = sh_prio[nx];
    if (nx == cur) begin
      sh_status[cur] = rrts_pkg::ST_RUNNING;
      return;
    end
    if (sh_status[cur] == rrts_pkg::ST_RUNNING) sh_status[cur] = rrts_pkg::ST_READY;
    if (sh_status[cur] == rrts_pkg::ST_READY) enqueue(cur, 1'b0);
    sh_status[nx] = rrts_pkg::ST_RUNNING;
    sh_running = 5'(nx);
  endfunction

  function automatic void change_status(input int t, input logic [2:0] s, input bit front,
                                        input bit sched);
    if (sh_status[t] != rrts_pkg::ST_READY && sh_status[t] != rrts_pkg::ST_RUNNING &&
        s == rrts_pkg::ST_READY)
      enqueue(t, front);
    if (s != rrts_pkg::ST_READY) unlink(t);
    sh_status[t] = s;
    if (sched) run_schedule();
  endfunction

  // Apply one command to the shadow and queue the result it gives
  function automatic void predict_step(input logic [1:0] op, input logic [4:0] id,
                                       input logic [7:0] pr, input logic [2:0] st,
                                       input bit front, input bit sched);
    sched_result_t r;
    logic [4:0] was;
    was = sh_running;
    case (op)
      rrts_pkg::OP_TICK: run_schedule();
      rrts_pkg::OP_CREATE: begin
        sh_status[id] = rrts_pkg::ST_READY;
        sh_prio[id] = pr;
        sh_slice[id] = pr;
        sh_elapsed[id] = '0;
        enqueue(int'(id), 1'b0);
      end
      rrts_pkg::OP_STATUS: if (st <= rrts_pkg::ST_DIED) change_status(int'(id), st, front, sched);
      default: change_status(int'(id), rrts_pkg::ST_DIED, 1'b0, sched);
    endcase
    r.cur = sh_running;
    r.prev = was;
    r.sw = (sh_running != was);
    r.cnt = sh_count;
    r.slice = sh_slice[sh_running];
    pending_results.push_back(r);
  endfunction

  task automatic send_command(input logic [1:0] op, input logic [4:0] id, input logic [7:0] pr,
                              input logic [2:0] st, input bit front, input bit sched);
    int gap;
    gap = rand_stall ? $urandom_range(0, 15) : 0;
    // Drop valid while idling between items
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode <= op;
    task_id <= id;
    priority_req <= pr;
    new_status <= st;
    to_front <= front;
    sched_req <= sched;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_step(op, id, pr, st, front, sched);
    @(negedge clk);
  endtask

  task automatic send_random(input int busy);
    logic [1:0] op;
    logic [2:0] st;
    op = 2'($urandom_range(0, 3));
    // Mostly ready/running transitions so the queue stays populated
    st = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 1));
    if ($urandom_range(0, 9) < busy) op = rrts_pkg::OP_TICK;
    send_command(op, 5'($urandom), 8'($urandom_range(0, 6) == 0 ? $urandom : $urandom_range(0, 6)),
                 st, 1'($urandom), 1'($urandom));
  endtask

  // Wait for every result, then let the block settle before a register write
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(negedge clk);
  endtask

  task automatic write_main_priority(input logic [7:0] v);
    drain();
    main_task_priority <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sh_prio[0] = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receive side: always ready without random stalls, else a drawn wait per item; plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!rand_stall) begin
      out_ready <= 1'b1;
    end else if (out_ready) begin
      out_ready <= 1'b0;
      rx_wait <= $urandom_range(0, 15);
    end else if (out_valid) begin
      if (rx_wait == 0) out_ready <= 1'b1;
      else rx_wait <= rx_wait - 1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    sched_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result", current_task, 0);
      end else begin
        w = pending_results.pop_front();
        if (current_task !== w.cur) report("current_task", current_task, w.cur);
        if (previous_task !== w.prev) report("previous_task", previous_task, w.prev);
        if (switched !== w.sw) report("switched", switched, w.sw);
        if (ready_count !== w.cnt) report("ready_count", ready_count, w.cnt);
        if (slice_left !== w.slice) report("slice_left", slice_left, w.slice);
      end
    end
  end

  task automatic test_directed();
    rand_stall = 1'b0;
    send_command(rrts_pkg::OP_TICK, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_CREATE, 5'd31, 8'd255, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_CREATE, 5'd1, 8'd0, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_CREATE, 5'd2, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_CREATE, 5'd2, 8'd2, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_STATUS, 5'd3, 8'd1, rrts_pkg::ST_READY, 1'b1, 1'b0);
    send_command(rrts_pkg::OP_STATUS, 5'd3, 8'd1, 3'd7, 1'b1, 1'b1);
    send_command(rrts_pkg::OP_STATUS, 5'd1, 8'd1, rrts_pkg::ST_BLOCKED, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_STATUS, 5'd1, 8'd1, rrts_pkg::ST_READY, 1'b1, 1'b0);
    send_command(rrts_pkg::OP_STATUS, 5'd2, 8'd1, rrts_pkg::ST_HANGING, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_STATUS, 5'd9, 8'd1, rrts_pkg::ST_BLOCKED, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_STATUS, 5'd0, 8'd1, rrts_pkg::ST_BLOCKED, 1'b0, 1'b1);
    send_command(rrts_pkg::OP_TICK, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_TICK, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_EXIT, 5'd31, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_EXIT, 5'(sh_running), 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_TICK, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    send_command(rrts_pkg::OP_STATUS, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b1);
    send_command(rrts_pkg::OP_STATUS, 5'd4, 8'd1, rrts_pkg::ST_DIED, 1'b1, 1'b1);
    send_command(rrts_pkg::OP_TICK, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    drain();
  endtask

  task automatic test_main_priority();
    write_main_priority(8'd1);
    repeat (6) send_command(rrts_pkg::OP_TICK, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
    write_main_priority(8'd255);
    repeat (4) send_command(rrts_pkg::OP_TICK, 5'd0, 8'd1, rrts_pkg::ST_READY, 1'b0, 1'b0);
  endtask

  task automatic test_random();
    rand_stall = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      write_main_priority(phase == 3 ? 8'd0 : 8'($urandom_range(1, 20)));
      for (int i = 0; i < 200; i++) send_random(phase + 3);
    end
    rand_stall = 1'b0;
    for (int i = 0; i < 60; i++) send_random(5);
  endtask

  task automatic test_backpressure();
    drain();
    rand_stall = 1'b0;
    @(negedge clk);
    hold_off <= 200;
    for (int i = 0; i < 30; i++) send_random(4);
    rand_stall = 1'b1;
  endtask

  initial begin
    shadow_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_main_priority();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_ram.sv
hw/rtl/rrts_task_store.sv
hw/rtl/round_robin_time_slice_scheduler.sv
bench/testbench.sv
